// ----- design/adc_autorange_controller_unit_assert.svh -----
// ----------------------------------------------------------------------------
// ADC autorange controller assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADC_AUTORANGE_CONTROLLER_UNIT_ASSERT_SVH
`define ADC_AUTORANGE_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define AARC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AARC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/aarc_pkg.sv -----
// ----------------------------------------------------------------------------
// ADC autorange controller package
// Shared types, codes and constants of the range controller.
// ----------------------------------------------------------------------------
package aarc_pkg;

	localparam int LevelW = 3;
	localparam logic [LevelW-1:0] TOP_LEVEL = 3'd4;
	localparam logic [LevelW-1:0] BOTTOM_LEVEL = 3'd1;

	localparam logic [7:0]  CHK_OFFSET   = 8'h9B;
	localparam logic [31:0] NEG_LIMIT    = 32'hF000_0000;
	localparam logic [31:0] ERR_BASE     = 32'h8000_0000;
	localparam logic [31:0] CHK_ERR_WORD = 32'h8000_0005;
	localparam logic [31:0] FORCED_WORD  = 32'h0000_009B;
	localparam logic [7:0]  HITS_MAX     = 8'hFF;

	localparam logic [1:0] RX_OK = 2'd0;

	localparam logic [1:0] REG_UPPER = 2'd0;
	localparam logic [1:0] REG_LOWER = 2'd1;
	localparam logic [1:0] REG_HITS  = 2'd2;

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_NORMAL = 3'd1,
		KIND_OVER   = 3'd2,
		KIND_UNDER  = 3'd3,
		KIND_RXERR  = 3'd4,
		KIND_CHKERR = 3'd5,
		KIND_NEG    = 3'd6
	} report_kind_t;

	typedef struct packed {
		logic [22:0] upper;
		logic [22:0] lower;
		logic [7:0]  hits;
	} cfg_t;

	typedef struct packed {
		logic [LevelW-1:0] level;
		logic [7:0]        count;
	} range_state_t;

	typedef struct packed {
		report_kind_t      kind;
		logic [31:0]       word;
		logic [LevelW-1:0] level;
		logic              set_level;
	} report_t;

endpackage

// ----- design/aarc_step.sv -----
// ----------------------------------------------------------------------------
// ADC autorange controller step logic
// Checks one word, classifies it and computes the next range state.
// ----------------------------------------------------------------------------
module aarc_step import aarc_pkg::*; (
	input  logic [31:0]  word,
	input  logic [1:0]   status,
	input  cfg_t         cfg,
	input  range_state_t cur,
	output range_state_t nxt,
	output report_t      rpt
);

	logic [7:0]  chk_sum;
	logic [31:0] sample;
	logic [23:0] value;
	logic [7:0]  cnt_inc;
	logic [LevelW-1:0] lvl_dn;

	assign chk_sum = word[31:24] + word[23:16] + word[15:8] + CHK_OFFSET;
	assign cnt_inc = (cur.count == HITS_MAX) ? HITS_MAX : cur.count + 8'd1;
	assign lvl_dn  = (cur.level <= 3'd2) ? BOTTOM_LEVEL : cur.level - 3'd1;

	always_comb begin
		rpt.kind      = KIND_NONE;
		rpt.word      = '0;
		rpt.set_level = 1'b0;
		nxt           = cur;
		if (status != RX_OK) begin
			sample   = ERR_BASE | {30'd0, status};
			rpt.kind = KIND_RXERR;
		end else if (word[7:0] != chk_sum) begin
			sample   = CHK_ERR_WORD;
			rpt.kind = KIND_CHKERR;
		end else if (word >= NEG_LIMIT && cur.level == BOTTOM_LEVEL) begin
			sample = FORCED_WORD;
		end else begin
			sample = word;
		end
		value = sample[31:8];
		if (sample[31]) begin
			if (rpt.kind == KIND_NONE) begin
				rpt.kind = KIND_NEG;
			end
			rpt.word = sample;
		end else if (value > {1'b0, cfg.upper}) begin
			nxt.count = '0;
			if (cur.level == TOP_LEVEL) begin
				rpt.kind = KIND_OVER;
				rpt.word = sample;
			end
			nxt.level     = TOP_LEVEL;
			rpt.set_level = 1'b1;
		end else if (value >= {1'b0, cfg.lower}) begin
			nxt.count = '0;
			rpt.kind  = KIND_NORMAL;
			rpt.word  = sample;
		end else begin
			nxt.count = cnt_inc;
			if (cnt_inc >= cfg.hits) begin
				nxt.count     = '0;
				nxt.level     = lvl_dn;
				rpt.set_level = 1'b1;
			end
			if (nxt.level == BOTTOM_LEVEL) begin
				rpt.kind = KIND_UNDER;
				rpt.word = sample;
			end
		end
		rpt.level = nxt.level;
	end

endmodule

// ----- design/adc_autorange_controller_unit.sv -----
// ----------------------------------------------------------------------------
// ADC autorange controller
// Validates converter words and steers the input range level.
// ----------------------------------------------------------------------------
// channel  handshake                     payload
// sample   sample_valid / sample_ready   sample_word, rx_status
// report   report_valid / report_ready   report_kind, report_word, range_level, set_level
// config   APB psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
// One word per cycle unless the report channel stalls: input register, step logic, result register.
// Range state updates as a word leaves the input register, so the next word sees it.
// A stalled result holds the input register; sample_ready drops only when both are full.
// Reset sets level 4, clears the low-hit count and loads the register defaults.
// ----------------------------------------------------------------------------
module adc_autorange_controller_unit import aarc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic [31:0] sample_word,
	input  logic [1:0]  rx_status,
	output logic        report_valid,
	input  logic        report_ready,
	output logic [2:0]  report_kind,
	output logic [31:0] report_word,
	output logic [2:0]  range_level,
	output logic        set_level,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t         cfg_q;
	range_state_t state_q;
	range_state_t state_nxt;
	report_t      rpt;
	report_t      report_q;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic [1:0]  status_s1;
	logic        out_valid_q;
	logic        out_free;
	logic        adv_s1;
	logic        cfg_wr;

	assign pready       = 1'b1;
	assign cfg_wr       = psel & penable & pwrite & pready;
	assign out_free     = ~out_valid_q | report_ready;
	assign adv_s1       = valid_s1 & out_free;
	assign sample_ready = ~valid_s1 | out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper <= 23'd7340032;
			cfg_q.lower <= 23'd524288;
			cfg_q.hits  <= 8'd5;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_UPPER: cfg_q.upper <= pwdata[22:0];
				REG_LOWER: cfg_q.lower <= pwdata[22:0];
				REG_HITS:  cfg_q.hits  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_UPPER: prdata = {9'd0, cfg_q.upper};
			REG_LOWER: prdata = {9'd0, cfg_q.lower};
			REG_HITS:  prdata = {24'd0, cfg_q.hits};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			word_s1   <= sample_word;
			status_s1 <= rx_status;
		end
	end

	aarc_step u_step (
		.word   (word_s1),
		.status (status_s1),
		.cfg    (cfg_q),
		.cur    (state_q),
		.nxt    (state_nxt),
		.rpt    (rpt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.level <= TOP_LEVEL;
			state_q.count <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			report_q <= rpt;
		end
	end

	assign report_valid = out_valid_q;
	assign report_kind  = report_q.kind;
	assign report_word  = report_q.word;
	assign range_level  = report_q.level;
	assign set_level    = report_q.set_level;

`include "adc_autorange_controller_unit_assert.svh"

	`AARC_ASSERT_IMP(a_level_range, 1'b1, state_q.level >= BOTTOM_LEVEL && state_q.level <= TOP_LEVEL, "range level out of bounds")
	`AARC_ASSERT_IMP(a_err_no_cmd, out_valid_q && (report_q.kind == KIND_RXERR || report_q.kind == KIND_CHKERR || report_q.kind == KIND_NEG), !report_q.set_level, "error word issued a range command")
	`AARC_ASSERT_IMP(a_over_top, out_valid_q && report_q.kind == KIND_OVER, report_q.set_level && report_q.level == TOP_LEVEL, "over-range report off the top level")
	`AARC_ASSERT_IMP(a_under_bottom, out_valid_q && report_q.kind == KIND_UNDER, report_q.level == BOTTOM_LEVEL, "under-range report above level 1")
	`AARC_ASSERT_NXT(a_state_hold, !adv_s1, $stable(state_q), "range state moved without a word")

endmodule

// ----- tb/adc_autorange_controller_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ADC autorange controller checker
// Watches the sample, report and register channels, keeps its own copy of
// the range state and thresholds, and compares each report word field by
// field against the oldest prediction. Counts failures for the testbench.
// ----------------------------------------------------------------------------
module adc_autorange_controller_unit_checker import aarc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	input  logic        sample_ready,
	input  logic [31:0] sample_word,
	input  logic [1:0]  rx_status,
	input  logic        report_valid,
	input  logic        report_ready,
	input  logic [2:0]  report_kind,
	input  logic [31:0] report_word,
	input  logic [2:0]  range_level,
	input  logic        set_level,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          pending,
	output int          fail_count
);

	localparam logic [22:0] UPPER_RST = 23'd7340032;
	localparam logic [22:0] LOWER_RST = 23'd524288;
	localparam logic [7:0]  HITS_RST  = 8'd5;
	localparam logic [3:0]  ADDR_UPPER = {REG_UPPER, 2'b00};
	localparam logic [3:0]  ADDR_LOWER = {REG_LOWER, 2'b00};
	localparam logic [3:0]  ADDR_HITS  = {REG_HITS, 2'b00};

	cfg_t         cfg;
	range_state_t range_st;
	report_t      pending_reports[$];
	report_t      predicted;
	report_t      oldest;

	task automatic advance_range(input logic [31:0] w, input logic [1:0] st,
			output report_t r);
		logic [31:0] smp;
		logic [7:0]  sum;
		logic [23:0] value;
		r.kind = KIND_NONE;
		r.word = '0;
		r.set_level = 1'b0;
		if (st != RX_OK) begin
			smp = ERR_BASE + st;
			r.kind = KIND_RXERR;
		end else begin
			sum = w[31:24] + w[23:16] + w[15:8] + CHK_OFFSET;
			if (w[7:0] == sum) begin
				smp = w;
			end else begin
				smp = CHK_ERR_WORD;
				r.kind = KIND_CHKERR;
			end
		end
		// words at or above NEG_LIMIT on the lowest range read as the forced small value
		if (r.kind == KIND_NONE && smp >= NEG_LIMIT && range_st.level == BOTTOM_LEVEL)
			smp = FORCED_WORD;
		if (smp >= ERR_BASE) begin
			if (r.kind == KIND_NONE)
				r.kind = KIND_NEG;
			r.word = smp;
		end else begin
			value = smp[31:8];
			if (value > {1'b0, cfg.upper}) begin
				range_st.count = '0;
				if (range_st.level == TOP_LEVEL) begin
					r.kind = KIND_OVER;
					r.word = smp;
				end
				range_st.level = TOP_LEVEL;
				r.set_level = 1'b1;
			end else if (value >= {1'b0, cfg.lower}) begin
				range_st.count = '0;
				r.kind = KIND_NORMAL;
				r.word = smp;
			end else begin
				if (range_st.count != HITS_MAX)
					range_st.count = range_st.count + 8'd1;
				if (range_st.count >= cfg.hits) begin
					range_st.count = '0;
					if (range_st.level <= 3'd2)
						range_st.level = BOTTOM_LEVEL;
					else
						range_st.level = range_st.level - 3'd1;
					r.set_level = 1'b1;
				end
				if (range_st.level == BOTTOM_LEVEL) begin
					r.kind = KIND_UNDER;
					r.word = smp;
				end
			end
		end
		r.level = range_st.level;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.upper = UPPER_RST;
			cfg.lower = LOWER_RST;
			cfg.hits = HITS_RST;
			range_st.level = TOP_LEVEL;
			range_st.count = '0;
			pending_reports.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_UPPER: cfg.upper = pwdata[22:0];
					ADDR_LOWER: cfg.lower = pwdata[22:0];
					ADDR_HITS:  cfg.hits = pwdata[7:0];
					default: ;
				endcase
			end
			if (report_valid && report_ready) begin
				if (pending_reports.size() == 0) begin
					fail_count++;
					$error("report word with none pending: kind %0d word %h",
						report_kind, report_word);
				end else begin
					oldest = pending_reports.pop_front();
					if (report_kind !== oldest.kind) begin
						fail_count++;
						$error("report_kind: expected %0d, got %0d", oldest.kind, report_kind);
					end
					if (report_word !== oldest.word) begin
						fail_count++;
						$error("report_word: expected %h, got %h", oldest.word, report_word);
					end
					if (range_level !== oldest.level) begin
						fail_count++;
						$error("range_level: expected %0d, got %0d", oldest.level, range_level);
					end
					if (set_level !== oldest.set_level) begin
						fail_count++;
						$error("set_level: expected %0d, got %0d", oldest.set_level, set_level);
					end
				end
			end
			if (sample_valid && sample_ready) begin
				advance_range(sample_word, rx_status, predicted);
				pending_reports.push_back(predicted);
			end
			pending <= pending_reports.size();
		end
	end

endmodule

// ----- tb/tb_adc_autorange_controller_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ADC autorange controller testbench
// Drives directed and random converter words through the sample channel under
// random back-pressure, rewrites the thresholds between phases, and lets the
// checker predict and compare every report word.
// ----------------------------------------------------------------------------
module tb_adc_autorange_controller_unit import aarc_pkg::*;;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT = 500;
	localparam int HOLD_LEN = 300;
	localparam logic [1:0] RX_ERR = 2'd1;
	localparam logic [1:0] RX_BUSY = 2'd2;
	localparam logic [1:0] RX_TIMEOUT = 2'd3;
	localparam logic [3:0] ADDR_UPPER = {REG_UPPER, 2'b00};
	localparam logic [3:0] ADDR_LOWER = {REG_LOWER, 2'b00};
	localparam logic [3:0] ADDR_HITS = {REG_HITS, 2'b00};
	localparam logic [3:0] ADDR_UNUSED = {2'd3, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_ready;
	logic [31:0] sample_word;
	logic [1:0]  rx_status;
	logic        report_valid;
	logic        report_ready;
	logic [2:0]  report_kind;
	logic [31:0] report_word;
	logic [2:0]  range_level;
	logic        set_level;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int pending;
	int fail_count;
	int cycle_cnt = 0;
	int tx_count = 0;

	logic [22:0] cur_upper;
	logic [22:0] cur_lower;
	logic [7:0]  cur_hits;

	adc_autorange_controller_unit uut (.*);

	adc_autorange_controller_unit_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("adc_autorange_controller_unit regression: fail");
			$finish;
		end
	end

	// report side: random stalls, one long hold-off, one calm stretch
	initial begin
		int got;
		int hold_left;
		bit held;
		got = 0;
		hold_left = 0;
		held = 1'b0;
		report_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (report_valid && report_ready)
				got++;
			if (!held && got == HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				report_ready <= 1'b0;
			end else if (got >= 1000 && got < 1200) begin
				report_ready <= 1'b1;
			end else begin
				report_ready <= ($urandom_range(99) >= 22);
			end
		end
	end

	function automatic logic [31:0] with_check(input logic [23:0] v);
		logic [7:0] sum;
		sum = v[23:16] + v[15:8] + v[7:0] + CHK_OFFSET;
		return {v, sum};
	endfunction

	task automatic send_word(input logic [31:0] w, input logic [1:0] st);
		if (tx_count < 700 || tx_count >= 900) begin
			while ($urandom_range(99) < 22) begin
				sample_valid <= 1'b0;
				sample_word <= $urandom;
				@(posedge clk);
			end
		end
		sample_valid <= 1'b1;
		sample_word <= w;
		rx_status <= st;
		do @(posedge clk); while (!sample_ready);
		tx_count++;
	endtask

	task automatic send_value(input logic [23:0] v);
		logic [31:0] w;
		logic [1:0]  st;
		w = with_check(v);
		if ($urandom_range(99) < 8)
			w[7:0] = 8'($urandom);
		st = ($urandom_range(99) < 10) ? 2'($urandom_range(3, 1)) : RX_OK;
		send_word(w, st);
	endtask

	task automatic drain_reports();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] a, input logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_range_phase(input logic [22:0] up, input logic [22:0] lo,
			input logic [7:0] hits, input int n);
		int sent;
		int len;
		int cat;
		logic [31:0] d;
		logic [23:0] v;
		drain_reports();
		// upper bits beyond each register's width are junk and must be dropped
		d = $urandom;
		d[22:0] = up;
		write_reg(ADDR_UPPER, d);
		d = $urandom;
		d[22:0] = lo;
		write_reg(ADDR_LOWER, d);
		d = $urandom;
		d[7:0] = hits;
		write_reg(ADDR_HITS, d);
		write_reg(ADDR_UNUSED, $urandom);
		cur_upper = up;
		cur_lower = lo;
		cur_hits = hits;
		sent = 0;
		while (sent < n) begin
			cat = $urandom_range(99);
			if (cat < 40) begin
				len = $urandom_range(((cur_hits > 30) ? 30 : cur_hits) + 2, 1);
				if (cur_hits > 30 && $urandom_range(9) == 0)
					len = cur_hits + 1;
				repeat (len) begin
					v = (cur_lower == 0) ? 24'($urandom) : 24'($urandom_range(cur_lower - 1, 0));
					send_value(v);
				end
				sent += len;
			end else begin
				if (cat < 60)
					send_value(24'($urandom_range(cur_upper, cur_lower)));
				else if (cat < 72)
					send_value((cur_upper == 23'h7FFFFF) ? 24'($urandom) :
						24'($urandom_range(24'h7FFFFF, cur_upper + 1)));
				else if (cat < 80)
					send_value(24'($urandom_range(24'hFFFFFF, 24'h800000)));
				else
					send_word($urandom, 2'($urandom_range(3)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample_word = '0;
		rx_status = RX_OK;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds, starting on the top range
		send_word(with_check(24'h7FFFFF), RX_OK);
		send_word(with_check(24'h700000), RX_OK);
		send_word(with_check(24'h080000), RX_OK);
		send_word($urandom, RX_ERR);
		send_word($urandom, RX_BUSY);
		send_word($urandom, RX_TIMEOUT);
		send_word(with_check(24'h123456) ^ 32'h0000_0001, RX_OK);
		send_word(32'hFFFF_FFFF, RX_OK);
		send_word(32'h0000_0000, RX_OK);
		send_word(with_check(24'h800000), RX_OK);
		repeat (4) send_word(with_check(24'h07FFFF), RX_OK);
		send_word(with_check(24'h400000), RX_OK);
		repeat (5) send_word(with_check(24'h000000), RX_OK);

		// single hit steps down to the bottom range
		drain_reports();
		write_reg(ADDR_HITS, 32'd1);
		send_word(with_check(24'h000001), RX_OK);
		send_word(with_check(24'h000002), RX_OK);
		send_word(with_check(24'hFFFFFF), RX_OK);
		send_word(with_check(24'hEFFFFF), RX_OK);
		send_word(with_check(24'h7FFFFF), RX_OK);

		run_range_phase(23'd7340032, 23'd524288, 8'd5, 210);
		run_range_phase(23'h7FFFFF, 23'h000000, 8'd255, 210);
		run_range_phase(23'h000000, 23'h7FFFFF, 8'd1, 210);
		run_range_phase(23'($urandom), 23'($urandom), 8'($urandom_range(8, 1)), 220);
		run_range_phase(23'h200000, 23'h600000, 8'd3, 200);
		run_range_phase(23'($urandom), 23'($urandom), 8'($urandom_range(255, 1)), 200);
		run_range_phase(23'h400000, 23'h100000, 8'd2, 220);
		drain_reports();

		if (fail_count == 0)
			$display("adc_autorange_controller_unit regression: pass");
		else
			$display("adc_autorange_controller_unit regression: fail");
		$finish;
	end

endmodule
